// File: hw/rtl/knn_majority_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// KNN classifier assertion macros
// Property shorthands for the port checker, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef KNN_MAJORITY_CLASSIFIER_TOP_DEFINES_SVH
`define KNN_MAJORITY_CLASSIFIER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KNN_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("knn checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define KNN_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("knn checker: next-cycle property failed");

`endif

// File: hw/rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// KNN classifier package
// Sizes, register codes, the queue entry type and clamping helpers.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int MAX_DIMS    = 64;
  localparam int MAX_K       = 16;
  localparam int NUM_CLASSES = 16;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W - 1;
  localparam int DIST_W     = 41;
  localparam int LABEL_W    = 4;
  localparam int CLASS_W    = 4;
  localparam int VOTERS_W   = 5;
  localparam int K_REG_W    = 5;
  localparam int DIMS_REG_W = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam int IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNTR_W = $clog2(MAX_DIMS + 1);
  localparam int KIDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KCNT_W = $clog2(MAX_K + 1);
  localparam int CIDX_W = $clog2(NUM_CLASSES);

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_NEIGHBOURS = 1'b0,
    REG_DIMENSIONS   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [CIDX_W-1:0]        cls;
    logic                     first;
    logic                     endp;
    logic                     last;
  } item_t;

  function automatic logic [CNTR_W-1:0] eff_dims(input logic [DIMS_REG_W-1:0] d);
    logic [CNTR_W-1:0] r;
    if (d == '0) begin
      r = CNTR_W'(1);
    end else if (int'(d) > MAX_DIMS) begin
      r = CNTR_W'(MAX_DIMS);
    end else begin
      r = CNTR_W'(d);
    end
    return r;
  endfunction

  function automatic logic [KCNT_W-1:0] eff_k(input logic [K_REG_W-1:0] k);
    logic [KCNT_W-1:0] r;
    if (k == '0) begin
      r = KCNT_W'(1);
    end else if (int'(k) > MAX_K) begin
      r = KCNT_W'(MAX_K);
    end else begin
      r = KCNT_W'(k);
    end
    return r;
  endfunction

  function automatic logic [CIDX_W-1:0] clamp_class(input logic [LABEL_W-1:0] l);
    logic [CIDX_W-1:0] r;
    if (int'(l) >= NUM_CLASSES) begin
      r = CIDX_W'(NUM_CLASSES - 1);
    end else begin
      r = CIDX_W'(l);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/knn_front.sv
// ----------------------------------------------------------------------------
// KNN classifier front end
// Tracks the coordinate counter, stores the query and forms coordinate deltas.
// ----------------------------------------------------------------------------
module knn_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic                                  kind_i,
  input  logic signed [knn_pkg::COORD_W-1:0]    coord_i,
  input  logic [knn_pkg::LABEL_W-1:0]           label_i,
  input  logic                                  last_i,
  input  logic [knn_pkg::DIMS_REG_W-1:0]        dims_i,
  output logic                                  q_push_o,
  output knn_pkg::item_t                        q_item_o,
  input  logic                                  q_full_i
);

  logic [knn_pkg::COORD_W-1:0] qmem [knn_pkg::MAX_DIMS];

  logic [knn_pkg::IDX_W-1:0]   cnt_q, cnt_d;
  logic [knn_pkg::CNTR_W-1:0]  idx_next;
  logic                        accept;
  logic                        end_vec;
  logic                        endp;
  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_move;
  logic [knn_pkg::COORD_W-1:0] s1_coord_q;
  logic [knn_pkg::COORD_W-1:0] qval_q;
  logic [knn_pkg::CIDX_W-1:0]  s1_cls_q;
  logic                        s1_first_q;
  logic                        s1_endp_q;
  logic                        s1_last_q;
  logic signed [knn_pkg::DIFF_W-1:0] diff;

  assign s1_move = s1_valid_q && !q_full_i;
  assign full_o  = s1_valid_q && q_full_i;
  assign accept  = push_i && !full_o;

  assign idx_next = knn_pkg::CNTR_W'(cnt_q) + knn_pkg::CNTR_W'(1);
  assign end_vec  = idx_next >= knn_pkg::eff_dims(dims_i);
  assign endp     = end_vec || ((kind_i == knn_pkg::KIND_POINT) && last_i);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = endp ? '0 : idx_next[knn_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (accept && (kind_i == knn_pkg::KIND_POINT)) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (kind_i == knn_pkg::KIND_QUERY) begin
        qmem[cnt_q] <= coord_i;
      end else begin
        qval_q     <= qmem[cnt_q];
        s1_coord_q <= coord_i;
        s1_cls_q   <= knn_pkg::clamp_class(label_i);
        s1_first_q <= (cnt_q == '0);
        s1_endp_q  <= endp;
        s1_last_q  <= last_i;
      end
    end
  end

  assign diff = $signed({s1_coord_q[knn_pkg::COORD_W-1], s1_coord_q})
              - $signed({qval_q[knn_pkg::COORD_W-1], qval_q});

  assign q_push_o       = s1_move;
  assign q_item_o.diff  = diff;
  assign q_item_o.cls   = s1_cls_q;
  assign q_item_o.first = s1_first_q;
  assign q_item_o.endp  = s1_endp_q;
  assign q_item_o.last  = s1_last_q;

endmodule

// File: hw/rtl/knn_fifo.sv
// ----------------------------------------------------------------------------
// KNN classifier decoupling queue
// Small register queue of coordinate deltas between the front and back ends.
// ----------------------------------------------------------------------------
module knn_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  knn_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output knn_pkg::item_t item_o,
  output logic           empty_o
);

  knn_pkg::item_t                entries_q [knn_pkg::FIFO_DEPTH];
  logic [knn_pkg::FPTR_W-1:0]    wptr_q, wptr_d;
  logic [knn_pkg::FPTR_W-1:0]    rptr_q, rptr_d;
  logic [knn_pkg::FPTR_W:0]      count_q, count_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (count_q == (knn_pkg::FPTR_W + 1)'(knn_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entries_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + knn_pkg::FPTR_W'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + knn_pkg::FPTR_W'(1) : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (knn_pkg::FPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (knn_pkg::FPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/knn_back.sv
// ----------------------------------------------------------------------------
// KNN classifier back end
// Squares and sums deltas, keeps the sorted neighbor list and runs the vote.
// ----------------------------------------------------------------------------
module knn_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  knn_pkg::item_t                    q_item_i,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  input  logic [knn_pkg::K_REG_W-1:0]       k_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [knn_pkg::CLASS_W-1:0]       predicted_class_o,
  output logic [knn_pkg::VOTERS_W-1:0]      voters_used_o
);

  typedef enum logic [1:0] {
    V_IDLE,
    V_COUNT,
    V_MAX,
    V_OUT
  } vstate_e;

  vstate_e                          state_q;
  logic                             advance;

  logic signed [2*knn_pkg::DIFF_W-1:0] prod;
  logic                             m_valid_q;
  logic [knn_pkg::SQ_W-1:0]         m_sq_q;
  logic [knn_pkg::CIDX_W-1:0]       m_cls_q;
  logic                             m_first_q;
  logic                             m_endp_q;
  logic                             m_last_q;

  logic [knn_pkg::DIST_W-1:0]       acc_q;
  logic [knn_pkg::CIDX_W-1:0]       pcls_q;
  logic [knn_pkg::DIST_W-1:0]       base;
  logic [knn_pkg::DIST_W:0]         sum_wide;
  logic [knn_pkg::DIST_W-1:0]       sum_sat;
  logic [knn_pkg::CIDX_W-1:0]       cls_now;

  logic                             ins_valid_q;
  logic [knn_pkg::DIST_W-1:0]       ins_d_q;
  logic [knn_pkg::CIDX_W-1:0]       ins_cls_q;
  logic                             ins_last_q;
  logic                             do_insert;

  logic [knn_pkg::DIST_W-1:0]       best_d_q [knn_pkg::MAX_K];
  logic [knn_pkg::CIDX_W-1:0]       best_c_q [knn_pkg::MAX_K];
  logic [knn_pkg::DIST_W-1:0]       new_d [knn_pkg::MAX_K];
  logic [knn_pkg::CIDX_W-1:0]       new_c [knn_pkg::MAX_K];
  logic [knn_pkg::MAX_K-1:0]        le;
  logic [knn_pkg::KCNT_W-1:0]       filled_q, filled_d;

  logic [knn_pkg::KCNT_W-1:0]       vi_q;
  logic [knn_pkg::CIDX_W-1:0]       ci_q;
  logic [knn_pkg::CIDX_W-1:0]       best_q;
  logic [knn_pkg::KCNT_W-1:0]       best_cnt_q;
  logic [knn_pkg::KCNT_W-1:0]       voters_q;
  logic [knn_pkg::KCNT_W-1:0]       voters_c;
  logic [knn_pkg::KCNT_W-1:0]       keff;
  logic [knn_pkg::KCNT_W-1:0]       count_q [knn_pkg::NUM_CLASSES];
  logic [knn_pkg::CIDX_W-1:0]       rd_addr;
  logic [knn_pkg::KCNT_W-1:0]       rd_cnt;
  logic                             out_valid_q;
  logic [knn_pkg::CIDX_W-1:0]       out_cls_q;
  logic [knn_pkg::KCNT_W-1:0]       out_voters_q;
  logic                             vote_done;

  assign advance = (state_q == V_IDLE);
  assign q_pop_o = advance && !q_empty_i;

  // Multiply stage.
  assign prod = q_item_i.diff * q_item_i.diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_sq_q    <= '0;
      m_cls_q   <= '0;
      m_first_q <= 1'b0;
      m_endp_q  <= 1'b0;
      m_last_q  <= 1'b0;
    end else if (advance) begin
      m_valid_q <= q_pop_o;
      m_sq_q    <= prod[knn_pkg::SQ_W-1:0];
      m_cls_q   <= q_item_i.cls;
      m_first_q <= q_item_i.first;
      m_endp_q  <= q_item_i.endp;
      m_last_q  <= q_item_i.last;
    end
  end

  // Accumulate stage.
  assign base     = m_first_q ? '0 : acc_q;
  assign sum_wide = {1'b0, base} + (knn_pkg::DIST_W + 1)'(m_sq_q);
  assign sum_sat  = sum_wide[knn_pkg::DIST_W] ? '1 : sum_wide[knn_pkg::DIST_W-1:0];
  assign cls_now  = m_first_q ? m_cls_q : pcls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pcls_q      <= '0;
      ins_valid_q <= 1'b0;
      ins_d_q     <= '0;
      ins_cls_q   <= '0;
      ins_last_q  <= 1'b0;
    end else if (advance) begin
      ins_valid_q <= m_valid_q && m_endp_q;
      if (m_valid_q) begin
        if (m_endp_q) begin
          acc_q      <= '0;
          pcls_q     <= m_last_q ? '0 : cls_now;
          ins_d_q    <= sum_sat;
          ins_cls_q  <= cls_now;
          ins_last_q <= m_last_q;
        end else begin
          acc_q  <= sum_sat;
          pcls_q <= cls_now;
        end
      end
    end
  end

  // Sorted insertion: the new point goes after every entry at or below it.
  assign do_insert = advance && ins_valid_q;

  always_comb begin
    for (int i = 0; i < knn_pkg::MAX_K; i++) begin
      le[i] = (knn_pkg::KCNT_W'(i) < filled_q) && (best_d_q[i] <= ins_d_q);
    end
    for (int i = 0; i < knn_pkg::MAX_K; i++) begin
      if (le[i]) begin
        new_d[i] = best_d_q[i];
        new_c[i] = best_c_q[i];
      end else if (i == 0) begin
        new_d[i] = ins_d_q;
        new_c[i] = ins_cls_q;
      end else if (le[i-1]) begin
        new_d[i] = ins_d_q;
        new_c[i] = ins_cls_q;
      end else begin
        new_d[i] = best_d_q[i-1];
        new_c[i] = best_c_q[i-1];
      end
    end
  end

  always_comb begin
    filled_d = filled_q;
    if (vote_done) begin
      filled_d = '0;
    end else if (do_insert && (int'(filled_q) < knn_pkg::MAX_K)) begin
      filled_d = filled_q + knn_pkg::KCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      for (int i = 0; i < knn_pkg::MAX_K; i++) begin
        best_d_q[i] <= new_d[i];
        best_c_q[i] <= new_c[i];
      end
    end
  end

  // Vote over the nearest entries, then a scan for the most frequent class.
  assign keff      = knn_pkg::eff_k(k_i);
  assign voters_c  = (keff < filled_q) ? keff : filled_q;
  assign rd_addr   = (state_q == V_COUNT) ? best_c_q[vi_q[knn_pkg::KIDX_W-1:0]] : ci_q;
  assign rd_cnt    = count_q[rd_addr];
  assign vote_done = (state_q == V_OUT) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= V_IDLE;
      vi_q         <= '0;
      ci_q         <= '0;
      best_q       <= '0;
      best_cnt_q   <= '0;
      voters_q     <= '0;
      out_valid_q  <= 1'b0;
      out_cls_q    <= '0;
      out_voters_q <= '0;
      for (int c = 0; c < knn_pkg::NUM_CLASSES; c++) begin
        count_q[c] <= '0;
      end
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        V_IDLE: begin
          if (do_insert && ins_last_q) begin
            state_q <= V_COUNT;
            vi_q    <= '0;
            for (int c = 0; c < knn_pkg::NUM_CLASSES; c++) begin
              count_q[c] <= '0;
            end
          end
        end
        V_COUNT: begin
          if (vi_q < voters_c) begin
            count_q[rd_addr] <= rd_cnt + knn_pkg::KCNT_W'(1);
            vi_q             <= vi_q + knn_pkg::KCNT_W'(1);
          end else begin
            state_q    <= V_MAX;
            ci_q       <= knn_pkg::CIDX_W'(1);
            best_q     <= '0;
            best_cnt_q <= count_q[0];
            voters_q   <= voters_c;
          end
        end
        V_MAX: begin
          if (rd_cnt > best_cnt_q) begin
            best_q     <= ci_q;
            best_cnt_q <= rd_cnt;
          end
          if (ci_q == knn_pkg::CIDX_W'(knn_pkg::NUM_CLASSES - 1)) begin
            state_q <= V_OUT;
          end else begin
            ci_q <= ci_q + knn_pkg::CIDX_W'(1);
          end
        end
        V_OUT: begin
          if (!out_valid_q) begin
            out_valid_q  <= 1'b1;
            out_cls_q    <= best_q;
            out_voters_q <= voters_q;
            state_q      <= V_IDLE;
          end
        end
        default: begin
          state_q <= V_IDLE;
        end
      endcase
    end
  end

  assign empty_o           = !out_valid_q;
  assign predicted_class_o = knn_pkg::CLASS_W'(out_cls_q);
  assign voters_used_o     = knn_pkg::VOTERS_W'(out_voters_q);

endmodule

// File: hw/rtl/knn_majority_classifier_top.sv
// ----------------------------------------------------------------------------
// KNN majority classifier
// Streams a query and labeled points, keeps the k nearest and votes a class.
// ----------------------------------------------------------------------------
// Channel   Handshake            Beat contents
// input     push / full          kind, coord_value, class_label, last_point
// result    empty / pop          predicted_class, voters_used
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front end takes one coordinate beat per cycle while full is low; dataset
// deltas then pass a four-entry queue into a multiply, accumulate and insert
// pipeline. After the last beat a result passes the front-end register, the
// queue, the multiply and accumulate stages and the insertion into the
// neighbor list, then a tally per voter, a scan of the classes and the post.
// The back end holds during the vote while the front end keeps taking beats
// until the queue fills.
// Reset clears all control state at once; the query store needs no clearing.
// ----------------------------------------------------------------------------
module knn_majority_classifier_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  kind_i,
  input  logic signed [knn_pkg::COORD_W-1:0]    coord_value_i,
  input  logic [knn_pkg::LABEL_W-1:0]           class_label_i,
  input  logic                                  last_point_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [knn_pkg::CLASS_W-1:0]           predicted_class_o,
  output logic [knn_pkg::VOTERS_W-1:0]          voters_used_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [knn_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [knn_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  logic [knn_pkg::K_REG_W-1:0]    k_q;
  logic [knn_pkg::DIMS_REG_W-1:0] dims_q;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  knn_pkg::item_t q_in;
  knn_pkg::item_t q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= knn_pkg::K_REG_W'(1);
      dims_q <= knn_pkg::DIMS_REG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        knn_pkg::REG_K_NEIGHBOURS: k_q    <= cfg_data_i[knn_pkg::K_REG_W-1:0];
        knn_pkg::REG_DIMENSIONS:   dims_q <= cfg_data_i[knn_pkg::DIMS_REG_W-1:0];
        default: begin
          k_q <= k_q;
        end
      endcase
    end
  end

  knn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .kind_i   (kind_i),
    .coord_i  (coord_value_i),
    .label_i  (class_label_i),
    .last_i   (last_point_i),
    .dims_i   (dims_q),
    .q_push_o (q_push),
    .q_item_o (q_in),
    .q_full_i (q_full)
  );

  knn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  knn_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_item_i          (q_out),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .k_i               (k_q),
    .empty_o           (empty),
    .pop_i             (pop),
    .predicted_class_o (predicted_class_o),
    .voters_used_o     (voters_used_o)
  );

endmodule

// File: hw/rtl/knn_chk.sv
// ----------------------------------------------------------------------------
// KNN classifier port checker
// Watches the top-level ports for result range, latency, drain and hold behavior.
// ----------------------------------------------------------------------------
`include "knn_majority_classifier_top_defines.svh"

module knn_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  push,
  input logic                                  full,
  input logic                                  kind_i,
  input logic                                  last_point_i,
  input logic                                  empty,
  input logic                                  pop,
  input logic [knn_pkg::CLASS_W-1:0]           predicted_class_o,
  input logic [knn_pkg::VOTERS_W-1:0]          voters_used_o
);

  logic last_beat;

  assign last_beat = push && !full && (kind_i == knn_pkg::KIND_POINT) && last_point_i;

  `KNN_ASSERT_NOW(a_voters_range, !empty, ((voters_used_o != '0) && (int'(voters_used_o) <= knn_pkg::MAX_K)))
  `KNN_ASSERT_NEXT(a_pop_drains, (pop && !empty), empty)
  `KNN_ASSERT_NOW(a_no_instant_result, $fell(empty), (!$past(last_beat, 1) && !$past(last_beat, 2)))
  `KNN_ASSERT_NEXT(a_result_holds, (!empty && !pop), (!empty && $stable(predicted_class_o) && $stable(voters_used_o)))

endmodule

bind knn_majority_classifier_top knn_chk u_chk (.*);
